// File: hdl/mcc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and port structs for the multichannel conv1d engine.
// Used by mcc_mac_bank and multichannel_conv1d_engine; depends on nothing.
package mcc_pkg;

	// Default geometry
	localparam int FILTERS_DEF  = 8;
	localparam int CHANNELS_DEF = 16;
	localparam int TAPS_DEF     = 5;
	localparam int SEQ_LEN_DEF  = 128;

	// Fixed field and datapath widths
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 8;
	localparam int POS_W      = 7;
	localparam int FNUM_W     = 3;
	localparam int ACC_W      = 24;
	localparam int PROD_W     = 18;
	localparam int ROW_MAX_W  = 11;
	localparam int FILT_MAX_W = 4;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 40;

	// Request kinds carried on s_tuser
	localparam logic REQ_WEIGHT = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// Weight store write port
	typedef struct packed {
		logic                  en;
		logic [FILT_MAX_W-1:0] filt;
		logic [ROW_MAX_W-1:0]  row;
		logic [BYTE_W-1:0]     data;
	} wr_t;

	// Multiply-accumulate issue port
	typedef struct packed {
		logic                 en;
		logic [ROW_MAX_W-1:0] row;
		logic [BYTE_W-1:0]    sample;
	} rd_t;

endpackage

// File: hdl/mcc_mac_bank.sv
`timescale 1ns / 1ps
// Weight store (one row per channel and tap, one byte lane per filter) and
// the per-filter multiply-accumulate pipeline. Depends on mcc_pkg.
module mcc_mac_bank #(
	parameter int FILTERS = mcc_pkg::FILTERS_DEF,
	parameter int NWIN    = mcc_pkg::CHANNELS_DEF * mcc_pkg::TAPS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  mcc_pkg::wr_t                            wr,
	input  mcc_pkg::rd_t                            rd,
	input  logic                                    signed_mode,
	input  logic                                    clr,
	output logic                                    busy,
	output logic [FILTERS-1:0][mcc_pkg::ACC_W-1:0]  acc
);

	localparam int ROW_W  = (NWIN > 1) ? $clog2(NWIN) : 1;
	localparam int FILT_W = (FILTERS > 1) ? $clog2(FILTERS) : 1;

	logic [FILTERS-1:0][mcc_pkg::BYTE_W-1:0] mem_q [NWIN];
	logic [FILTERS-1:0][mcc_pkg::BYTE_W-1:0] wrow_s1;
	logic [mcc_pkg::BYTE_W-1:0]              samp_s1;
	logic signed [mcc_pkg::PROD_W-1:0]       prod_s2 [FILTERS];
	logic [FILTERS-1:0][mcc_pkg::ACC_W-1:0]  acc_q;
	logic                                    v_s1;
	logic                                    v_s2;

	// Read a byte as int8 or uint8
	function automatic logic signed [mcc_pkg::BYTE_W:0] opnd(
		input logic                      smode,
		input logic [mcc_pkg::BYTE_W-1:0] b
	);
		opnd = $signed({smode & b[mcc_pkg::BYTE_W-1], b});
	endfunction

	// Weight store: byte-lane write, registered row read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.row[ROW_W-1:0]][wr.filt[FILT_W-1:0]] <= wr.data;
		end
		wrow_s1 <= mem_q[rd.row[ROW_W-1:0]];
		samp_s1 <= rd.sample;
	end

	// One product per filter
	always_ff @(posedge clk) begin
		for (int f = 0; f < FILTERS; f++) begin
			prod_s2[f] <= opnd(signed_mode, wrow_s1[f]) * opnd(signed_mode, samp_s1);
		end
	end

	// Track issued reads through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd.en;
			v_s2 <= v_s1;
		end
	end

	// Accumulate; clear when a new window starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			for (int f = 0; f < FILTERS; f++) begin
				acc_q[f] <= acc_q[f] + mcc_pkg::ACC_W'(prod_s2[f]);
			end
		end
	end

	assign busy = v_s1 | v_s2;
	assign acc  = acc_q;

endmodule

// File: hdl/multichannel_conv1d_engine.sv
`timescale 1ns / 1ps
// Multichannel conv1d engine: 5-column sample window, one MAC per filter,
// result bank drained onto the output stream. Depends on mcc_pkg, mcc_mac_bank.
// A weight write or a sample that does not complete a column leaves the engine idle.
// A column completion without results passes through the shift state; one with
// results runs the MAC, drain, copy and shift states, the MAC state making the single
// MAC pass over the weight store, one row per cycle. Copy waits for a free result bank.
// Results leave one per cycle while m_tready is high, from a result bank while the next column loads.
// Reset clears window, column count, control and sets signed mode; weights are
// undefined until written.
module multichannel_conv1d_engine #(
	parameter int FILTERS  = mcc_pkg::FILTERS_DEF,
	parameter int CHANNELS = mcc_pkg::CHANNELS_DEF,
	parameter int TAPS     = mcc_pkg::TAPS_DEF,
	parameter int SEQ_LEN  = mcc_pkg::SEQ_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,  // signed_mode
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// filter_index[2:0], channel_index[6:3], tap_index[9:7], data_byte[17:10],
	// sequence_start[18], zero fill [23:19]
	input  logic [mcc_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,    // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// filter_number[2:0], position[9:3], conv_sum[33:10], zero fill [39:34]
	output logic [mcc_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tlast     // last_of_column
);

	localparam int NWIN   = CHANNELS * TAPS;
	localparam int ROW_W  = (NWIN > 1) ? $clog2(NWIN) : 1;
	localparam int FILT_W = (FILTERS > 1) ? $clog2(FILTERS) : 1;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MAC   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_COPY  = 5'b01000,
		ST_SHIFT = 5'b10000
	} state_t;

	state_t                                  state_q;
	state_t                                  state_d;
	logic                                    mode_q;
	logic [mcc_pkg::CNT_W-1:0]               cnt_q;
	logic [mcc_pkg::POS_W-1:0]               pos_q;
	logic [mcc_pkg::BYTE_W-1:0]              win_q [NWIN];
	logic [CH_W-1:0]                         ch_q;
	logic [TAP_W-1:0]                        tap_q;
	logic [ROW_W-1:0]                        row_q;
	logic [FILTERS-1:0][mcc_pkg::ACC_W-1:0]  obank_q;
	logic [mcc_pkg::POS_W-1:0]               opos_q;
	logic [FILT_W-1:0]                       osel_q;
	logic                                    obusy_q;

	logic [2:0]                              fi;
	logic [3:0]                              ci;
	logic [2:0]                              ti;
	logic [mcc_pkg::BYTE_W-1:0]              dbyte;
	logic                                    sstart;
	logic                                    accept;
	logic                                    is_sample;
	logic                                    ch_ok;
	logic                                    samp_acc;
	logic                                    complete;
	logic                                    fire;
	logic [mcc_pkg::CNT_W-1:0]               cnt_base;
	logic [mcc_pkg::CNT_W:0]                 done;
	logic                                    last_issue;
	logic                                    copy_go;
	logic                                    out_hs;
	logic                                    pipe_busy;
	logic [FILTERS-1:0][mcc_pkg::ACC_W-1:0]  acc;
	mcc_pkg::wr_t                            wr;
	mcc_pkg::rd_t                            rd;

	// Unpack the input transaction
	assign fi     = s_tdata[2:0];
	assign ci     = s_tdata[6:3];
	assign ti     = s_tdata[9:7];
	assign dbyte  = s_tdata[17:10];
	assign sstart = s_tdata[18];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_sample = (s_tuser == mcc_pkg::REQ_SAMPLE);
	assign ch_ok     = (int'(ci) < CHANNELS);
	assign samp_acc  = accept && is_sample && ch_ok;
	assign complete  = samp_acc && (int'(ci) == CHANNELS - 1);
	assign cnt_base  = sstart ? '0 : cnt_q;
	assign done      = {1'b0, cnt_base} + (mcc_pkg::CNT_W + 1)'(1);
	assign fire      = complete && (int'(done) >= TAPS);

	assign last_issue = (int'(ch_q) == CHANNELS - 1) && (int'(tap_q) == TAPS - 1);
	assign copy_go    = (state_q == ST_COPY) && !obusy_q;
	assign out_hs     = m_tvalid && m_tready;

	// Weight write port
	always_comb begin
		wr      = '0;
		wr.en   = accept && (s_tuser == mcc_pkg::REQ_WEIGHT) && (int'(fi) < FILTERS)
			&& ch_ok && (int'(ti) < TAPS);
		wr.filt = {1'b0, fi};
		wr.row  = mcc_pkg::ROW_MAX_W'(int'(ci) * TAPS + int'(ti));
		wr.data = dbyte;
	end

	// MAC issue port: the rotating window always presents its head byte
	always_comb begin
		rd        = '0;
		rd.en     = (state_q == ST_MAC);
		rd.row    = mcc_pkg::ROW_MAX_W'(row_q);
		rd.sample = win_q[0];
	end

	mcc_mac_bank #(
		.FILTERS (FILTERS),
		.NWIN    (NWIN)
	) u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.rd          (rd),
		.signed_mode (mode_q),
		.clr         (fire),
		.busy        (pipe_busy),
		.acc         (acc)
	);

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					state_d = ST_MAC;
				end else if (complete) begin
					state_d = ST_SHIFT;
				end
			end
			ST_MAC: begin
				if (last_issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!pipe_busy) state_d = ST_COPY;
			end
			ST_COPY: begin
				if (!obusy_q) state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Column count and window position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (complete) begin
			cnt_q <= (int'(done) >= SEQ_LEN) ? '0 : done[mcc_pkg::CNT_W-1:0];
		end else if (samp_acc && sstart) begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pos_q <= mcc_pkg::POS_W'(done - (mcc_pkg::CNT_W + 1)'(TAPS));
		end
	end

	// Walk channel and tap; the weight row is channel * TAPS + tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q  <= '0;
			tap_q <= '0;
			row_q <= '0;
		end else if (fire) begin
			ch_q  <= '0;
			tap_q <= '0;
			row_q <= '0;
		end else if (state_q == ST_MAC) begin
			if (int'(ch_q) == CHANNELS - 1) begin
				ch_q  <= '0;
				tap_q <= tap_q + TAP_W'(1);
				row_q <= ROW_W'(int'(tap_q) + 1);
			end else begin
				ch_q  <= ch_q + CH_W'(1);
				row_q <= ROW_W'(int'(row_q) + TAPS);
			end
		end
	end

	// Sample window: store into newest column, rotate during MAC, age columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NWIN; i++) begin
				win_q[i] <= '0;
			end
		end else if (samp_acc) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (int'(ci) == i) win_q[(TAPS-1)*CHANNELS + i] <= dbyte;
			end
		end else if (state_q == ST_MAC) begin
			for (int i = 0; i < NWIN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[NWIN-1] <= win_q[0];
		end else if (state_q == ST_SHIFT) begin
			for (int i = 0; i < NWIN - CHANNELS; i++) begin
				win_q[i] <= win_q[i+CHANNELS];
			end
		end
	end

	// Result bank: load finished sums, drain one filter per transaction
	always_ff @(posedge clk) begin
		if (copy_go) begin
			obank_q <= acc;
			opos_q  <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obusy_q <= 1'b0;
			osel_q  <= '0;
		end else if (copy_go) begin
			obusy_q <= 1'b1;
			osel_q  <= '0;
		end else if (out_hs) begin
			if (m_tlast) begin
				obusy_q <= 1'b0;
			end else begin
				osel_q <= osel_q + FILT_W'(1);
			end
		end
	end

	assign m_tvalid = obusy_q;
	assign m_tlast  = (int'(osel_q) == FILTERS - 1);
	assign m_tdata  = {6'b0, obank_q[osel_q], opos_q, mcc_pkg::FNUM_W'(osel_q)};

	// The last result of a column frees the bank: m_tvalid is low in the cycle after it
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("result bank reloaded in the cycle after the last result");

	// Sums are copied only after the MAC pipeline has drained
	a_copy_drained: assert property (@(posedge clk) disable iff (!arst_n)
		copy_go |-> !pipe_busy)
		else $error("result bank loaded while products are in flight");

	// No weight write may overlap reads of the weight store
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_busy |-> !s_tready)
		else $error("input accepted while the MAC pipeline is busy");

	// The tap walk stays within the filter length
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (int'(tap_q) < TAPS))
		else $error("tap counter beyond the filter length");

endmodule
